/* design/text_console_cursor_control_assert.svh */
// assertion macros for the text console cursor control block
// expects clk and arst_n in the scope of each use
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_ASSERT_SVH

// same-cycle implication, off during reset
`define TCCC_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tccc assertion failed");

// next-cycle implication, off during reset
`define TCCC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tccc assertion failed");

`endif

/* design/tccc_pkg.sv */
// shared types and constants of the text console cursor control block
// no dependencies
package tccc_pkg;

	// window limits
	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 64;

	// character codes
	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	// render commands
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_DRAW   = 2'd0;
	localparam cmd_t CMD_CLEAR  = 2'd1;
	localparam cmd_t CMD_SCROLL = 2'd2;

	// configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ENABLE     = 3'd0;
	localparam cfg_idx_t CFG_WIN_LEFT   = 3'd1;
	localparam cfg_idx_t CFG_WIN_TOP    = 3'd2;
	localparam cfg_idx_t CFG_WIN_RIGHT  = 3'd3;
	localparam cfg_idx_t CFG_WIN_BOTTOM = 3'd4;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		cmd_t       command;
		logic [6:0] cell_col;
		logic [5:0] cell_row;
		logic [7:0] glyph;
		logic       last;
	} result_t;

endpackage

/* design/text_console_cursor_control.sv */
// text console cursor control: cursor update and render command queue
// depends on tccc_pkg and text_console_cursor_control_assert.svh
// results: an accepted item's results are registered into the result queue, whose head drives the outputs
// throughput: one item per cycle while in_stall is low and each item gives at most one result; an item
// with two results fills two queue slots, which the single output port shows one after the other
// reset: cursor, queue pointers and registers clear at once on arst_n low; queue storage is not reset
`include "text_console_cursor_control_assert.svh"

module text_console_cursor_control (
	input  logic              clk,
	input  logic              arst_n,
	// character items
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_code,
	// render command items
	output logic              out_valid,
	input  logic              out_stall,
	output tccc_pkg::cmd_t    command,
	output logic [6:0]        cell_col,
	output logic [5:0]        cell_row,
	output logic [7:0]        glyph,
	output logic              last,
	// register writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  tccc_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]        cfg_data
);
	import tccc_pkg::*;

	localparam int CNT_W = FIFO_AW + 1;

	// configuration registers
	logic       enable_q;
	logic [6:0] win_left_q;
	logic [5:0] win_top_q;
	logic [6:0] win_right_q;
	logic [5:0] win_bottom_q;

	// cursor state
	logic [7:0] cursor_col_q;
	logic [6:0] cursor_row_q;

	// result queue
	result_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	logic acc;
	logic pop;

	// cursor datapath, wide enough for the overshoot past the edges
	logic [8:0] col_a, col_b;
	logic [7:0] row_a, row_b, row_c;
	logic [8:0] left9, right9;
	logic [7:0] bottom8;
	logic       have_cell;
	logic       scroll;
	result_t    cell_res;
	result_t    scroll_res;
	result_t    slot0, slot1;
	logic [1:0] num_wr;

	// writes are always taken; the user must keep the block idle whenever config changes, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			win_left_q   <= 7'd0;
			win_top_q    <= 6'd0;
			win_right_q  <= 7'd127;
			win_bottom_q <= 6'd63;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLE:     enable_q     <= cfg_data[0];
				CFG_WIN_LEFT:   win_left_q   <= cfg_data[6:0];
				CFG_WIN_TOP:    win_top_q    <= cfg_data[5:0];
				CFG_WIN_RIGHT:  win_right_q  <= cfg_data[6:0];
				CFG_WIN_BOTTOM: win_bottom_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// stall while the queue cannot take a worst-case pair of results
	assign in_stall  = count_q > CNT_W'(FIFO_DEPTH - 2);
	assign acc       = in_valid && !in_stall;
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;

	// right and bottom edges clamped to the maximum window
	always_comb begin
		left9 = {2'b00, win_left_q};
		if ({2'b00, win_right_q} > 9'(MAX_COLS - 1))
			right9 = 9'(MAX_COLS - 1);
		else
			right9 = {2'b00, win_right_q};
		if ({2'b00, win_bottom_q} > 8'(MAX_ROWS - 1))
			bottom8 = 8'(MAX_ROWS - 1);
		else
			bottom8 = {2'b00, win_bottom_q};
	end

	// per-character cursor move and the cell command it may cause
	always_comb begin
		col_a     = {1'b0, cursor_col_q};
		row_a     = {1'b0, cursor_row_q};
		have_cell = 1'b0;
		cell_res  = '0;
		unique case (char_code)
			CH_TAB: begin
				col_a = ({1'b0, cursor_col_q} + 9'd8) & ~9'd7;
			end
			CH_CR: begin
				col_a = left9;
			end
			CH_LF: begin
				row_a = {1'b0, cursor_row_q} + 8'd1;
				col_a = left9;
			end
			CH_BS: begin
				// never steps past the left edge
				if ({1'b0, cursor_col_q} > left9) begin
					col_a             = {1'b0, cursor_col_q} - 9'd1;
					have_cell         = 1'b1;
					cell_res.command  = CMD_CLEAR;
					cell_res.cell_col = col_a[6:0];
					cell_res.cell_row = cursor_row_q[5:0];
				end
			end
			default: begin
				have_cell         = 1'b1;
				cell_res.command  = CMD_DRAW;
				cell_res.cell_col = cursor_col_q[6:0];
				cell_res.cell_row = cursor_row_q[5:0];
				cell_res.glyph    = char_code;
				col_a             = {1'b0, cursor_col_q} + 9'd1;
			end
		endcase

		// wrap past the right edge
		if (col_a > right9) begin
			col_b = left9;
			row_b = row_a + 8'd1;
		end else begin
			col_b = col_a;
			row_b = row_a;
		end

		// past the bottom: scroll and hold on the bottom row
		scroll = row_b > bottom8;
		row_c  = scroll ? bottom8 : row_b;

		cell_res.last      = !scroll;
		scroll_res         = '0;
		scroll_res.command = CMD_SCROLL;
		scroll_res.last    = 1'b1;

		// pack the results into consecutive queue slots
		slot0  = have_cell ? cell_res : scroll_res;
		slot1  = scroll_res;
		num_wr = enable_q ? ({1'b0, have_cell} + {1'b0, scroll}) : 2'd0;
	end

	// cursor update on each accepted item while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= 8'd0;
			cursor_row_q <= 7'd0;
		end else if (acc && enable_q) begin
			cursor_col_q <= col_b[7:0];
			cursor_row_q <= row_c[6:0];
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (acc)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(num_wr);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (acc ? CNT_W'(num_wr) : CNT_W'(0))
				- (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// queue storage, payload only
	always_ff @(posedge clk) begin
		if (acc && num_wr != 2'd0)
			fifo_q[wr_ptr_q] <= slot0;
		if (acc && num_wr == 2'd2)
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= slot1;
	end

	assign command  = fifo_q[rd_ptr_q].command;
	assign cell_col = fifo_q[rd_ptr_q].cell_col;
	assign cell_row = fifo_q[rd_ptr_q].cell_row;
	assign glyph    = fifo_q[rd_ptr_q].glyph;
	assign last     = fifo_q[rd_ptr_q].last;

	// checks
	`TCCC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(FIFO_DEPTH))
	`TCCC_ASSERT_NEXT(a_disabled_hold, acc && !enable_q, $stable(cursor_col_q) && $stable(cursor_row_q))
	`TCCC_ASSERT_IMP(a_scroll_blank, out_valid && command == CMD_SCROLL, cell_col == 7'd0 && cell_row == 6'd0 && glyph == 8'd0)
	`TCCC_ASSERT_NEXT(a_pair_kept, pop && !last, out_valid)

endmodule

/* tb/text_console_cursor_control_test.sv */
// self-checking testbench for the text console cursor control block
// holds its own cursor tracker, drives character items and register writes, checks commands
// depends on tccc_pkg and the text_console_cursor_control rtl
module text_console_cursor_control_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tccc_pkg::*;

	// tracks the cursor and window, and queues the render commands each character should cause
	class cursor_tracker;
		logic       en;
		logic [6:0] win_left;
		logic [5:0] win_top;
		logic [6:0] win_right;
		logic [5:0] win_bottom;
		logic [7:0] cur_col;
		logic [6:0] cur_row;
		result_t    pending_cmds [$];
		int         errors;

		function new();
			en         = 1'b0;
			win_left   = 7'd0;
			win_top    = 6'd0;
			win_right  = 7'd127;
			win_bottom = 6'd63;
			cur_col    = 8'd0;
			cur_row    = 7'd0;
			errors     = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [7:0] d);
			case (idx)
				CFG_ENABLE:     en         = d[0];
				CFG_WIN_LEFT:   win_left   = d[6:0];
				CFG_WIN_TOP:    win_top    = d[5:0];
				CFG_WIN_RIGHT:  win_right  = d[6:0];
				CFG_WIN_BOTTOM: win_bottom = d[5:0];
				default: ;
			endcase
		endfunction

		// one accepted character: move the cursor and queue up to two commands
		function void take_char(logic [7:0] c);
			int unsigned col, row, rgt, bot, n;
			result_t     cmds [2];
			if (!en)
				return;
			col = cur_col;
			row = cur_row;
			rgt = win_right;
			bot = win_bottom;
			n   = 0;
			if (rgt > MAX_COLS - 1)
				rgt = MAX_COLS - 1;
			if (bot > MAX_ROWS - 1)
				bot = MAX_ROWS - 1;
			if (c == CH_TAB) begin
				col = (col + 8) & ~32'd7;
			end else if (c == CH_CR) begin
				col = win_left;
			end else if (c == CH_LF) begin
				row = row + 1;
				col = win_left;
			end else if (c == CH_BS) begin
				if (col > win_left) begin
					col = col - 1;
					cmds[n] = '{CMD_CLEAR, 7'(col), 6'(row), 8'h00, 1'b0};
					n++;
				end
			end else begin
				cmds[n] = '{CMD_DRAW, 7'(col), 6'(row), c, 1'b0};
				n++;
				col = col + 1;
			end
			if (col > rgt) begin
				col = win_left;
				row = row + 1;
			end
			if (row > bot) begin
				cmds[n] = '{CMD_SCROLL, 7'd0, 6'd0, 8'h00, 1'b0};
				n++;
				row = bot;
			end
			if (n > 0)
				cmds[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++)
				pending_cmds.push_back(cmds[i]);
			cur_col = 8'(col);
			cur_row = 7'(row);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_cmd(result_t got);
			result_t want;
			if (pending_cmds.size() == 0) begin
				$display("%0t: command expected none, got %0d col %0d row %0d glyph %0d",
					$time, got.command, got.cell_col, got.cell_row, got.glyph);
				errors++;
				return;
			end
			want = pending_cmds.pop_front();
			compare_field("command", want.command, got.command);
			compare_field("cell_col", want.cell_col, got.cell_col);
			compare_field("cell_row", want.cell_row, got.cell_row);
			compare_field("glyph", want.glyph, got.glyph);
			compare_field("last", want.last, got.last);
		endfunction

		function int pending();
			return pending_cmds.size();
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] char_code = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	cmd_t       command;
	logic [6:0] cell_col;
	logic [5:0] cell_row;
	logic [7:0] glyph;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_idx_t   cfg_index = CFG_ENABLE;
	logic [7:0] cfg_data  = 8'h00;

	cursor_tracker tracker;

	// sender burst state: items left in the current burst, then an idle gap
	int burst_left = 0;
	int idle_gap   = 1;

	// receiver stall pattern state
	int stall_mode = 0;
	int stall_tick = 0;
	int stall_len  = 50;

	text_console_cursor_control u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.command   (command),
		.cell_col  (cell_col),
		.cell_row  (cell_row),
		.glyph     (glyph),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stall pattern: free-flowing, coin toss, periodic or mostly stalled,
	// each held for a random stretch of cycles
	always @(posedge clk) begin
		stall_tick++;
		if (stall_tick >= stall_len) begin
			stall_tick = 0;
			stall_mode = $urandom_range(0, 3);
			stall_len  = $urandom_range(20, 300);
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= (stall_tick % 5) < 3;
			default: out_stall <= $urandom_range(0, 9) < 8;
		endcase
	end

	// sample every handshake at the clock edge; outputs are checked before the
	// item of the same edge is noted, though no item can answer in its own cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.match_cmd(result_t'({command, cell_col, cell_row, glyph, last}));
			if (in_valid && !in_stall)
				tracker.take_char(char_code);
			if (cfg_valid && cfg_ready)
				tracker.set_reg(cfg_index, cfg_data);
		end
	end

	// present one character and hold it until accepted; close the burst with an idle gap
	task automatic send_char(logic [7:0] c);
		in_valid  <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat (idle_gap) @(posedge clk);
			// now and then a long stretch with no idling at all
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 15);
			idle_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
				: $urandom_range(1, 3);
		end else begin
			burst_left--;
		end
	endtask

	// one register write, then a pause with the write channel quiet
	task automatic write_reg(cfg_idx_t idx, logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender paused: wait for every queued command, then let the pipeline drain
	task automatic settle();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all five registers; unused upper data bits carry noise
	task automatic set_window(logic en, logic [6:0] l, logic [5:0] t, logic [6:0] r,
		logic [5:0] b);
		write_reg(CFG_ENABLE, {7'($urandom), en});
		write_reg(CFG_WIN_LEFT, {1'($urandom), l});
		write_reg(CFG_WIN_TOP, {2'($urandom), t});
		write_reg(CFG_WIN_RIGHT, {1'($urandom), r});
		write_reg(CFG_WIN_BOTTOM, {2'($urandom), b});
	endtask

	// control codes often enough to move the cursor around, glyphs otherwise
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return CH_TAB;
			1: return CH_CR;
			2: return CH_LF;
			3, 4: return CH_BS;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int         enabled_sent;
		int         phase;
		int         count;
		int         span;
		logic       en;
		logic [6:0] l, r;
		logic [5:0] t, b;

		tracker = new();
		enabled_sent = 0;
		phase = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// still disabled out of reset: these are ignored
		send_char("A");
		send_char(CH_LF);
		send_char(CH_BS);
		in_valid <= 1'b0;
		settle();

		// full window: glyph extremes, clear, return, backspace at the left edge, tab, line feed
		set_window(1'b1, 7'd0, 6'd0, 7'd127, 6'd63);
		send_char(8'h00);
		send_char(8'hFF);
		send_char("A");
		send_char(CH_BS);
		send_char(CH_CR);
		send_char(CH_BS);
		send_char(CH_TAB);
		send_char(CH_LF);
		in_valid <= 1'b0;
		settle();

		// small window with the cursor left outside it: tab wrap, line feed scroll,
		// codes next to the control codes, then a glyph that both wraps and scrolls
		set_window(1'b1, 7'd4, 6'd1, 7'd12, 6'd2);
		send_char(CH_BS);
		send_char(8'h7F);
		send_char(CH_TAB);
		send_char(CH_TAB);
		send_char(8'h80);
		send_char(CH_LF);
		send_char(CH_CR);
		send_char(CH_BS);
		send_char(8'd7);
		send_char(8'd11);
		send_char(8'd12);
		send_char(8'd14);
		send_char(8'h55);
		send_char(8'hAA);
		send_char("x");
		send_char("y");
		send_char("z");
		in_valid <= 1'b0;
		settle();

		// random phases, each with a fresh window; the first three are the corner settings, the fourth runs disabled
		while (enabled_sent < 1850) begin
			en = 1'b1;
			case (phase)
				0: begin
					l = 7'd0;   t = 6'd0;  r = 7'd127; b = 6'd63;
				end
				1: begin
					// single cell in the far corner
					l = 7'd127; t = 6'd63; r = 7'd127; b = 6'd63;
				end
				2: begin
					// left beyond right and top beyond bottom
					l = 7'd127; t = 6'd63; r = 7'd0;   b = 6'd0;
				end
				3: begin
					en = 1'b0;
					l = 7'($urandom); t = 6'($urandom); r = 7'($urandom); b = 6'($urandom);
				end
				default: begin
					l = 7'($urandom);
					t = 6'($urandom);
					if ($urandom_range(0, 3) == 0) begin
						r = 7'($urandom);
					end else begin
						span = l + $urandom_range(0, 40);
						r = (span > 127) ? 7'd127 : 7'(span);
					end
					if ($urandom_range(0, 3) == 0) begin
						b = 6'($urandom);
					end else begin
						span = t + $urandom_range(0, 6);
						b = (span > 63) ? 6'd63 : 6'(span);
					end
				end
			endcase
			set_window(en, l, t, r, b);

			count = en ? $urandom_range(40, 200) : 30;
			repeat (count)
				send_char(pick_char());
			if (en)
				enabled_sent += count;
			in_valid <= 1'b0;
			settle();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hard limit, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
